@@ hdl/sitoda_pkg.sv @@
// shared constants, types and state encoding for the signed integer to decimal text block
// standalone package, used by sitoda_dabble and signed_int_to_decimal_ascii
`default_nettype none

package sitoda_pkg;

    localparam int VALUE_BITS = 32;
    localparam int CHAR_BITS  = 6;

    // number of decimal digits in 2^(bits-1), the largest magnitude
    function automatic int digits_of_pow2(input int bits);
        logic [63:0] lim;
        logic [63:0] p;
        int          d;
        begin
            lim = 64'd1 << (bits - 1);
            p   = 64'd10;
            d   = 1;
            for (int i = 0; i < 19; i++) begin
                if (p <= lim) begin
                    d = d + 1;
                    p = p * 64'd10;
                end
            end
            return d;
        end
    endfunction

    localparam int NUM_DIGITS = digits_of_pow2(VALUE_BITS);
    localparam int BCD_BITS   = 4 * NUM_DIGITS;
    localparam int CNT_W      = $clog2(VALUE_BITS);
    localparam int LEFT_W     = $clog2(NUM_DIGITS + 1);

    localparam logic [CHAR_BITS-1:0] ASCII_ZERO  = CHAR_BITS'(48);
    localparam logic [CHAR_BITS-1:0] ASCII_MINUS = CHAR_BITS'(45);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SIGN,
        ST_SKIP,
        ST_DIGIT
    } state_t;

    // converter result: done pulse and the packed decimal digits
    typedef struct packed {
        logic                done;
        logic [BCD_BITS-1:0] bcd;
    } dab_res_t;

endpackage

`default_nettype wire

@@ hdl/sitoda_dabble.sv @@
// bit-serial binary to packed decimal converter, one magnitude bit per cycle (shift and add 3)
// depends on sitoda_pkg
`default_nettype none

module sitoda_dabble (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               start,
    input  wire logic [sitoda_pkg::VALUE_BITS-1:0]  magnitude,
    output sitoda_pkg::dab_res_t                    res
);

    logic [sitoda_pkg::VALUE_BITS-1:0] bin_reg, bin_next;
    logic [sitoda_pkg::BCD_BITS-1:0]   bcd_reg, bcd_next;
    logic [sitoda_pkg::BCD_BITS-1:0]   adj;
    logic [sitoda_pkg::CNT_W-1:0]      cnt_reg, cnt_next;
    logic                              busy_reg, busy_next;
    logic                              done_reg, done_next;

    always_comb begin
        // digits of five or more get three added before the shift
        adj = bcd_reg;
        for (int i = 0; i < sitoda_pkg::NUM_DIGITS; i++) begin
            if (bcd_reg[4*i +: 4] >= 4'd5) begin
                adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            end
        end

        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            bin_next  = magnitude;
            bcd_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            bin_next = {bin_reg[sitoda_pkg::VALUE_BITS-2:0], 1'b0};
            bcd_next = {adj[sitoda_pkg::BCD_BITS-2:0], bin_reg[sitoda_pkg::VALUE_BITS-1]};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == sitoda_pkg::CNT_W'(sitoda_pkg::VALUE_BITS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
        cnt_reg <= cnt_next;
    end

    assign res.done = done_reg;
    assign res.bcd  = bcd_reg;

endmodule

`default_nettype wire

@@ hdl/signed_int_to_decimal_ascii.sv @@
// signed integer to decimal ASCII text, one character per output transfer
// depends on sitoda_pkg and sitoda_dabble
//
// Use: an input transfer on s_value (valid/ready) carries one signed integer. The block
// returns its decimal text on the m_ channel, one ASCII character per transfer: a minus
// sign first for a negative value, then the digits most significant first without
// leading zeros, m_last high on the final one. Zero gives a single '0'; the most
// negative value prints in full.
// Timing: after acceptance the magnitude goes through the shift-and-add-3 converter at
// one bit per cycle, and the packed digits are then handed over to the digit shifter.
// Leading zero digits are then dropped one per cycle (up to NUM_DIGITS-1 = 9), and the
// digits go to the output register, each as soon as that register is free. While the
// receiver keeps m_ready high, a value occupies the block as long with few digits as
// with many, since each dropped zero stands in for a digit sent; a negative value adds
// the minus sign. The bit-serial converter takes the bulk of it. s_ready is high only
// while no value is in work; the last character sits in the output register, so the
// next value can be taken meanwhile.
// Stalls: while a character waits with m_ready low, the output register and digit loads hold.
// Reset (aresetn low, synchronous) drops any value in work and empties the output.
`default_nettype none

module signed_int_to_decimal_ascii (
    input  wire logic                                      aclk,
    input  wire logic                                      aresetn,
    input  wire logic                                      s_valid,
    output logic                                           s_ready,
    input  wire logic signed [sitoda_pkg::VALUE_BITS-1:0]  s_value,
    output logic                                           m_valid,
    input  wire logic                                      m_ready,
    output logic [sitoda_pkg::CHAR_BITS-1:0]               m_character,
    output logic                                           m_last
);

    sitoda_pkg::state_t state_reg, state_next;

    logic                                  neg_reg, neg_next;
    logic [sitoda_pkg::BCD_BITS-1:0]       dig_reg, dig_next;
    logic [sitoda_pkg::LEFT_W-1:0]         left_reg, left_next;
    logic                                  m_valid_reg, m_valid_next;
    logic [sitoda_pkg::CHAR_BITS-1:0]      char_reg, char_next;
    logic                                  last_reg, last_next;

    logic                                  accept;
    logic                                  out_free;
    logic [sitoda_pkg::VALUE_BITS-1:0]     magnitude;
    logic [3:0]                            top_digit;
    logic                                  one_left;
    logic                                  take_bcd;
    logic                                  load_sign;
    logic                                  load_digit;
    logic                                  drop_zero;
    sitoda_pkg::dab_res_t                  dab_res;

    assign accept    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign magnitude = s_value[sitoda_pkg::VALUE_BITS-1] ? ($unsigned(~s_value) + 1'b1)
                                                         : $unsigned(s_value);
    assign top_digit = dig_reg[sitoda_pkg::BCD_BITS-1 -: 4];
    assign one_left  = (left_reg == sitoda_pkg::LEFT_W'(1));

    sitoda_dabble u_dabble (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (accept),
        .magnitude (magnitude),
        .res       (dab_res)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            sitoda_pkg::ST_IDLE: begin
                if (s_valid) state_next = sitoda_pkg::ST_CONV;
            end
            sitoda_pkg::ST_CONV: begin
                if (dab_res.done) begin
                    state_next = neg_reg ? sitoda_pkg::ST_SIGN : sitoda_pkg::ST_SKIP;
                end
            end
            sitoda_pkg::ST_SIGN: begin
                if (out_free) state_next = sitoda_pkg::ST_SKIP;
            end
            sitoda_pkg::ST_SKIP: begin
                if (top_digit != 4'd0 || one_left) state_next = sitoda_pkg::ST_DIGIT;
            end
            sitoda_pkg::ST_DIGIT: begin
                if (out_free && one_left) state_next = sitoda_pkg::ST_IDLE;
            end
            default: state_next = sitoda_pkg::ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        s_ready    = 1'b0;
        take_bcd   = 1'b0;
        load_sign  = 1'b0;
        load_digit = 1'b0;
        drop_zero  = 1'b0;
        unique case (state_reg)
            sitoda_pkg::ST_IDLE:  s_ready    = 1'b1;
            sitoda_pkg::ST_CONV:  take_bcd   = dab_res.done;
            sitoda_pkg::ST_SIGN:  load_sign  = out_free;
            sitoda_pkg::ST_SKIP:  drop_zero  = (top_digit == 4'd0) && !one_left;
            sitoda_pkg::ST_DIGIT: load_digit = out_free;
            default: ;
        endcase
    end

    // datapath
    always_comb begin
        neg_next     = neg_reg;
        dig_next     = dig_reg;
        left_next    = left_reg;
        char_next    = char_reg;
        last_next    = last_reg;
        m_valid_next = m_valid_reg;

        if (accept) neg_next = s_value[sitoda_pkg::VALUE_BITS-1];

        if (take_bcd) begin
            dig_next  = dab_res.bcd;
            left_next = sitoda_pkg::LEFT_W'(sitoda_pkg::NUM_DIGITS);
        end else if (drop_zero || load_digit) begin
            dig_next  = {dig_reg[sitoda_pkg::BCD_BITS-5:0], 4'd0};
            left_next = left_reg - 1'b1;
        end

        if (m_ready) m_valid_next = 1'b0;
        if (load_sign) begin
            char_next    = sitoda_pkg::ASCII_MINUS;
            last_next    = 1'b0;
            m_valid_next = 1'b1;
        end else if (load_digit) begin
            char_next    = sitoda_pkg::ASCII_ZERO + {{(sitoda_pkg::CHAR_BITS-4){1'b0}}, top_digit};
            last_next    = one_left;
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= sitoda_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        neg_reg  <= neg_next;
        dig_reg  <= dig_next;
        left_reg <= left_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_character = char_reg;
    assign m_last      = last_reg;

endmodule

`default_nettype wire
